// File: sv/multi_slot_periodic_oneshot_timer_defines.svh
// Assertion macros for the multi-slot periodic / one-shot timer.
// Included by the checker; depends on nothing else.
`ifndef MULTI_SLOT_PERIODIC_ONESHOT_TIMER_DEFINES_SVH
`define MULTI_SLOT_PERIODIC_ONESHOT_TIMER_DEFINES_SVH

// same-cycle implication
`define MSOT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSOT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/msot_pkg.sv
// Shared types and constants of the multi-slot timer.
// No dependencies.
`timescale 1ns / 1ps

package msot_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int SLOT_W        = 4;
	localparam int VALUE_W       = 16;
	localparam logic [VALUE_W-1:0] DEFAULT_PERIOD = 16'd1000;

	typedef enum logic [1:0] {
		KIND_ADVANCE  = 2'd0,
		KIND_PERIODIC = 2'd1,
		KIND_ONESHOT  = 2'd2,
		KIND_CANCEL   = 2'd3
	} kind_t;

endpackage

// File: sv/multi_slot_periodic_oneshot_timer.sv
// Top level of the multi-slot periodic / one-shot timer table.
// Depends on msot_pkg and msot_ram.
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// command  | start & !busy        | kind, slot, value
// fire     | fired (one cycle)    | fired_slot, fire_count, was_one_shot, last
//
// Start and cancel complete while idle, without raising busy. An advance scans
// each slot in turn, paced by the RAM read port, and runs the shared divider
// (one remainder bit per cycle) for each periodic slot that fires.
// Reset clears all slots at once; remaining time and period need no clearing.
// The receiver cannot stall: each fire result shows for exactly one cycle.
`timescale 1ns / 1ps

module multi_slot_periodic_oneshot_timer #(
	parameter int NUM_SLOTS = msot_pkg::NUM_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic [msot_pkg::SLOT_W-1:0]  slot,
	input  logic [msot_pkg::VALUE_W-1:0] value,
	output logic                         fired,
	output logic [msot_pkg::SLOT_W-1:0]  fired_slot,
	output logic [msot_pkg::VALUE_W-1:0] fire_count,
	output logic                         was_one_shot,
	output logic                         last
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int VW    = msot_pkg::VALUE_W;
	localparam int SW    = msot_pkg::SLOT_W;
	localparam int CNT_W = $clog2(VW);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EVAL,
		S_DIV,
		S_FLUSH
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] one_shot_q;
	logic [VW-1:0]        ms_q;
	logic [VW-1:0]        per_q;
	logic [VW-1:0]        div_n_q;
	logic [VW-1:0]        div_r_q;
	logic [CNT_W-1:0]     div_cnt_q;
	logic                 pend_v_q;
	logic [SW-1:0]        pend_slot_q;
	logic [VW-1:0]        pend_cnt_q;
	logic                 pend_one_q;
	logic                 fired_q;
	logic [SW-1:0]        fired_slot_q;
	logic [VW-1:0]        fire_count_q;
	logic                 was_one_shot_q;
	logic                 last_q;

	msot_pkg::kind_t      cmd_kind;
	logic                 accept;
	logic                 slot_ok;
	logic [IDX_W-1:0]     cmd_idx;
	logic [VW-1:0]        start_per;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [2*VW-1:0]      ram_wdata;
	logic                 ram_re;
	logic [2*VW-1:0]      ram_rdata;

	logic [VW-1:0]        rem_w;
	logic [VW-1:0]        per_raw;
	logic [VW-1:0]        per_w;
	logic                 expires;
	logic                 cur_one_shot;

	logic [VW:0]          div_shift;
	logic                 div_ge;
	logic [VW-1:0]        div_r_next;
	logic [VW-1:0]        div_n_next;
	logic                 div_last;

	logic                 fire_now;
	logic [VW-1:0]        fire_cnt;
	logic                 fire_one;
	logic                 step_done;

	assign cmd_kind  = msot_pkg::kind_t'(kind);
	assign accept    = start && !busy;
	assign slot_ok   = int'(slot) < NUM_SLOTS;
	assign cmd_idx   = IDX_W'(slot);
	assign start_per = (value == '0) ? msot_pkg::DEFAULT_PERIOD : value;

	assign rem_w        = ram_rdata[VW-1:0];
	assign per_raw      = ram_rdata[2*VW-1:VW];
	assign per_w        = (per_raw == '0) ? msot_pkg::DEFAULT_PERIOD : per_raw;
	assign expires      = rem_w <= ms_q;
	assign cur_one_shot = one_shot_q[idx_q];

	assign div_shift  = {div_r_q, div_n_q[VW-1]};
	assign div_ge     = div_shift >= {1'b0, per_q};
	assign div_r_next = div_ge ? VW'(div_shift - {1'b0, per_q}) : div_shift[VW-1:0];
	assign div_n_next = {div_n_q[VW-2:0], div_ge};
	assign div_last   = (state_q == S_DIV) && (div_cnt_q == '0);

	assign ram_re = (state_q == S_SCAN) && active_q[idx_q];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {per_raw, VW'(rem_w - ms_q)};
		fire_now  = 1'b0;
		fire_cnt  = VW'(1);
		fire_one  = 1'b1;
		step_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				ram_waddr = cmd_idx;
				if (accept && slot_ok && cmd_kind == msot_pkg::KIND_PERIODIC) begin
					ram_we    = 1'b1;
					ram_wdata = {start_per, start_per};
				end else if (accept && slot_ok && cmd_kind == msot_pkg::KIND_ONESHOT) begin
					ram_we    = 1'b1;
					ram_wdata = {value, value};
				end
			end
			S_EVAL: begin
				if (!expires) begin
					ram_we    = 1'b1;
					step_done = 1'b1;
				end else if (cur_one_shot) begin
					fire_now  = 1'b1;
					step_done = 1'b1;
				end
			end
			S_DIV: begin
				if (div_last) begin
					ram_we    = 1'b1;
					ram_wdata = {per_q, VW'(per_q - div_r_next)};
					fire_now  = 1'b1;
					fire_cnt  = VW'(div_n_next + VW'(1));
					fire_one  = 1'b0;
					step_done = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	msot_ram #(
		.WIDTH (2 * VW),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			idx_q          <= '0;
			active_q       <= '0;
			one_shot_q     <= '0;
			ms_q           <= '0;
			per_q          <= '0;
			div_n_q        <= '0;
			div_r_q        <= '0;
			div_cnt_q      <= '0;
			pend_v_q       <= 1'b0;
			pend_slot_q    <= '0;
			pend_cnt_q     <= '0;
			pend_one_q     <= 1'b0;
			fired_q        <= 1'b0;
			fired_slot_q   <= '0;
			fire_count_q   <= '0;
			was_one_shot_q <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			fired_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd_kind)
							msot_pkg::KIND_ADVANCE: begin
								ms_q    <= value;
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
							msot_pkg::KIND_PERIODIC: begin
								if (slot_ok) begin
									active_q[cmd_idx]   <= 1'b1;
									one_shot_q[cmd_idx] <= 1'b0;
								end
							end
							msot_pkg::KIND_ONESHOT: begin
								if (slot_ok) begin
									active_q[cmd_idx]   <= 1'b1;
									one_shot_q[cmd_idx] <= 1'b1;
								end
							end
							default: begin
								if (slot_ok) begin
									active_q[cmd_idx]   <= 1'b0;
									one_shot_q[cmd_idx] <= 1'b0;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (active_q[idx_q]) begin
						state_q <= S_EVAL;
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_FLUSH;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_EVAL: begin
					if (expires && cur_one_shot) begin
						active_q[idx_q]   <= 1'b0;
						one_shot_q[idx_q] <= 1'b0;
					end else if (expires) begin
						div_n_q   <= VW'(ms_q - rem_w);
						div_r_q   <= '0;
						per_q     <= per_w;
						div_cnt_q <= CNT_W'(VW - 1);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					div_n_q   <= div_n_next;
					div_r_q   <= div_r_next;
					div_cnt_q <= div_cnt_q - CNT_W'(1);
				end
				S_FLUSH: begin
					if (pend_v_q) begin
						fired_q        <= 1'b1;
						fired_slot_q   <= pend_slot_q;
						fire_count_q   <= pend_cnt_q;
						was_one_shot_q <= pend_one_q;
						last_q         <= 1'b1;
					end
					pend_v_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// hold the newest fire until the next one shows it was not the last
			if (fire_now) begin
				if (pend_v_q) begin
					fired_q        <= 1'b1;
					fired_slot_q   <= pend_slot_q;
					fire_count_q   <= pend_cnt_q;
					was_one_shot_q <= pend_one_q;
					last_q         <= 1'b0;
				end
				pend_v_q    <= 1'b1;
				pend_slot_q <= SW'(idx_q);
				pend_cnt_q  <= fire_cnt;
				pend_one_q  <= fire_one;
			end

			if (step_done) begin
				if (idx_q == LAST_IDX) begin
					state_q <= S_FLUSH;
				end else begin
					idx_q   <= idx_q + IDX_W'(1);
					state_q <= S_SCAN;
				end
			end
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign fired        = fired_q;
	assign fired_slot   = fired_slot_q;
	assign fire_count   = fire_count_q;
	assign was_one_shot = was_one_shot_q;
	assign last         = last_q;

endmodule

// File: sv/msot_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module msot_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/msot_checker.sv
// Port-level checker for the multi-slot timer, bound to the top level.
// Depends on msot_pkg and multi_slot_periodic_oneshot_timer_defines.svh.
`timescale 1ns / 1ps
`include "multi_slot_periodic_oneshot_timer_defines.svh"

module msot_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [1:0]                   kind,
	input logic [msot_pkg::SLOT_W-1:0]  slot,
	input logic [msot_pkg::VALUE_W-1:0] value,
	input logic                         fired,
	input logic [msot_pkg::SLOT_W-1:0]  fired_slot,
	input logic [msot_pkg::VALUE_W-1:0] fire_count,
	input logic                         was_one_shot,
	input logic                         last
);

	logic is_adv;

	assign is_adv = msot_pkg::kind_t'(kind) == msot_pkg::KIND_ADVANCE;

	`MSOT_ASSERT_NEXT(a_adv_busy, clk, arst_n, start && !busy && is_adv, busy, "advance did not go busy")
	`MSOT_ASSERT_NEXT(a_cmd_one, clk, arst_n, start && !busy && !is_adv, !busy, "start or cancel took more than one cycle")
	`MSOT_ASSERT_NOW(a_mid_busy, clk, arst_n, fired && !last, busy, "non-final fire outside an advance")
	`MSOT_ASSERT_NOW(a_one_cnt, clk, arst_n, fired && was_one_shot, fire_count == msot_pkg::VALUE_W'(1), "one-shot fire count is not one")
	`MSOT_ASSERT_NEXT(a_last_gap, clk, arst_n, fired && last, !fired, "fire right after final fire")

endmodule

bind multi_slot_periodic_oneshot_timer msot_checker u_msot_checker (.*);
